// File: rtl/rer_pkg.sv
// Package with the shared types and fixed-point constants of the exposin radius evaluator.
package rer_pkg;

    // Q.28 angle and logarithm constants.
    localparam logic [30:0] Q28_TWO_PI  = 31'd1686629713;
    localparam logic [29:0] Q28_PI      = 30'd843314857;
    localparam logic [28:0] Q28_HALF_PI = 29'd421657428;
    localparam logic [27:0] Q28_LN2     = 28'd186065280;
    localparam logic [28:0] Q28_ONE     = 29'd268435456;

    // Width of the range-reduction word, number of reduction cells and number of sine and exponential terms.
    localparam int RED_W     = 49;
    localparam int MOD_CELLS = 18;
    localparam int SIN_TERMS = 8;
    localparam int EXP_TERMS = 12;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCALE_FACTOR  = 3'd0;
    localparam logic [2:0] CFG_DYNAMIC_RANGE = 3'd1;
    localparam logic [2:0] CFG_WINDING_RATE  = 3'd2;
    localparam logic [2:0] CFG_PHASE_OFFSET  = 3'd3;

    // Data handed along a series cell: current term, multiplier, running sum and a tag.
    typedef struct packed {
        logic [31:0]        term;
        logic [31:0]        mult;
        logic signed [33:0] sum;
        logic [4:0]         tag;
    } t_ser;

endpackage

// File: rtl/rer_if.sv
// Request channel interfaces of the exposin radius evaluator.
interface rer_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] theta;

    modport source (output valid, output theta, input ready);
    modport sink (input valid, input theta, output ready);
endinterface

interface rer_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] radius;
    logic        saturated;

    modport source (output valid, output radius, output saturated, input ready);
    modport sink (input valid, input radius, input saturated, output ready);
endinterface

// File: rtl/rer_mod_cell.sv
// Range-reduction cell: conditionally subtracts a shifted two-pi step from the angle word.
module rer_mod_cell #(
    parameter int SHIFT = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [rer_pkg::RED_W-1:0] i_val,
    output logic                    o_valid,
    output logic [rer_pkg::RED_W-1:0] o_val
);

    localparam logic [rer_pkg::RED_W-1:0] STEP =
        rer_pkg::RED_W'(rer_pkg::Q28_TWO_PI) << SHIFT;

    logic                      r_valid;
    logic [rer_pkg::RED_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= (i_val >= STEP) ? (i_val - STEP) : i_val;
        end
    end

    assign o_valid = r_valid;
    assign o_val   = r_val;

endmodule

// File: rtl/rer_series_cell.sv
// Series cell: one Taylor term, multiply then exact division by a constant, over two stages.
module rer_series_cell #(
    parameter int DIVISOR  = 6,
    parameter bit SUBTRACT = 1'b1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  rer_pkg::t_ser i_data,
    output logic          o_valid,
    output rer_pkg::t_ser o_data
);

    // Reciprocal exact for every 32-bit dividend.
    localparam int          DIV_BITS = $clog2(DIVISOR);
    localparam int          SH       = 32 + DIV_BITS;
    localparam logic [33:0] RECIP    =
        34'(((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

    logic [63:0]   w_prod;
    logic [65:0]   w_qfull;
    logic [65:0]   w_qshift;
    logic [31:0]   w_q;
    logic          r_a_valid;
    logic [31:0]   r_a_p;
    rer_pkg::t_ser r_a;
    logic          r_b_valid;
    rer_pkg::t_ser r_b;

    assign w_prod   = 64'(i_data.term) * 64'(i_data.mult);
    assign w_qfull  = 66'(r_a_p) * 66'(RECIP);
    assign w_qshift = w_qfull >> SH;
    assign w_q      = w_qshift[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p       <= w_prod[59:28];
            r_a         <= i_data;
            r_b.term    <= w_q;
            r_b.mult    <= r_a.mult;
            r_b.tag     <= r_a.tag;
            if (SUBTRACT) begin
                r_b.sum <= r_a.sum - $signed({2'b00, w_q});
            end else begin
                r_b.sum <= r_a.sum + $signed({2'b00, w_q});
            end
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;

endmodule

// File: rtl/exposin_radius_evaluator_core.sv
// Top level of the exposin radius evaluator: r = k0 * exp(k1 * sin(k2*theta + k3)).
//
//   Channel   Direction  Payload                          Handshake
//   i_in      request    theta   (signed Q16.16 radians)  valid / ready
//   o_out     result     radius  (Q16.16), saturated      valid / ready
//   i_cfg_*   write      idx 0..3, 32-bit data            write enable, no wait
//
// One request is taken per cycle while ready is high; the pipeline depth is set by the
// length of the cell chains (18 reduction cells, 8 sine cells
// and 12 exponential cells of two stages each, plus the fixed stages around them).
// Reset is synchronous and active low; it clears every valid bit and restores the
// coefficient registers. A two-entry output queue holds results while the sink stalls;
// the whole pipeline freezes, and ready drops, only once both entries are full.
module exposin_radius_evaluator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rer_in_if.sink      i_in,
    rer_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Coefficient registers.
    logic [31:0]        r_k0;
    logic signed [15:0] r_k1;
    logic signed [15:0] r_k2;
    logic signed [15:0] r_k3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0 <= 32'd65536;
            r_k1 <= 16'sd0;
            r_k2 <= 16'sd4096;
            r_k3 <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rer_pkg::CFG_SCALE_FACTOR:  r_k0 <= i_cfg_data;
                rer_pkg::CFG_DYNAMIC_RANGE: r_k1 <= i_cfg_data[15:0];
                rer_pkg::CFG_WINDING_RATE:  r_k2 <= i_cfg_data[15:0];
                rer_pkg::CFG_PHASE_OFFSET:  r_k3 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless both output entries are occupied.
    logic [1:0] r_cnt;
    logic       w_en;

    assign w_en       = (r_cnt != 2'd2);
    assign i_in.ready = w_en;

    // Stage 1: form the sine argument in Q.28 and add a multiple of two pi that makes
    // it non-negative, so that the reduction cells only ever subtract.
    logic signed [47:0] w_mul;
    logic [49:0]        w_arg;
    logic               r_s1_valid;
    logic [rer_pkg::RED_W-1:0] r_s1_arg;

    assign w_mul = r_k2 * $signed(i_in.theta);
    assign w_arg = 50'(w_mul) + (50'(r_k3) <<< 15) + (50'(rer_pkg::Q28_TWO_PI) << 17);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_arg <= w_arg[rer_pkg::RED_W-1:0];
        end
    end

    // Reduction chain: each cell takes off one binary multiple of two pi.
    logic                      w_mod_valid [0:rer_pkg::MOD_CELLS];
    logic [rer_pkg::RED_W-1:0] w_mod_val   [0:rer_pkg::MOD_CELLS];

    assign w_mod_valid[0] = r_s1_valid;
    assign w_mod_val[0]   = r_s1_arg;

    for (genvar j = 0; j < rer_pkg::MOD_CELLS; j++) begin : g_mod
        rer_mod_cell #(
            .SHIFT(rer_pkg::MOD_CELLS - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_mod_valid[j]),
            .i_val   (w_mod_val[j]),
            .o_valid (w_mod_valid[j+1]),
            .o_val   (w_mod_val[j+1])
        );
    end

    // Fold the reduced angle into the first quadrant and square it.
    logic [30:0]   w_r;
    logic          w_neg;
    logic [29:0]   w_mag;
    logic [28:0]   w_m;
    logic [57:0]   w_sq;
    logic          r_f_valid;
    rer_pkg::t_ser r_f;

    assign w_r   = w_mod_val[rer_pkg::MOD_CELLS][30:0];
    assign w_neg = (w_r >= 31'(rer_pkg::Q28_PI));
    assign w_mag = w_neg ? 30'(rer_pkg::Q28_TWO_PI - w_r) : w_r[29:0];
    assign w_m   = (w_mag > 30'(rer_pkg::Q28_HALF_PI)) ? 29'(rer_pkg::Q28_PI - w_mag)
                                                       : w_mag[28:0];
    assign w_sq  = 58'(w_m) * 58'(w_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= w_mod_valid[rer_pkg::MOD_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f.term <= 32'(w_m);
            r_f.mult <= 32'(w_sq[57:28]);
            r_f.sum  <= $signed(34'(w_m));
            r_f.tag  <= {4'b0000, w_neg};
        end
    end

    // Sine series: terms alternate in sign, divisors (2k)(2k+1).
    logic          w_sin_valid [0:rer_pkg::SIN_TERMS];
    rer_pkg::t_ser w_sin       [0:rer_pkg::SIN_TERMS];

    assign w_sin_valid[0] = r_f_valid;
    assign w_sin[0]       = r_f;

    for (genvar k = 1; k <= rer_pkg::SIN_TERMS; k++) begin : g_sin
        rer_series_cell #(
            .DIVISOR  ((2 * k) * (2 * k + 1)),
            .SUBTRACT ((k % 2) == 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sin_valid[k-1]),
            .i_data  (w_sin[k-1]),
            .o_valid (w_sin_valid[k]),
            .o_data  (w_sin[k])
        );
    end

    // Clamp |sin| to [0, 1] and scale by |k1|; the exponent sign combines both signs.
    logic signed [33:0] w_ssum;
    logic [28:0]        w_s;
    logic [15:0]        w_k1mag;
    logic [44:0]        w_emul;
    logic               r_e_valid;
    logic [31:0]        r_e_mag;
    logic               r_e_neg;

    assign w_ssum  = w_sin[rer_pkg::SIN_TERMS].sum;
    assign w_s     = (w_ssum < 0) ? 29'd0 :
                     (w_ssum > $signed(34'(rer_pkg::Q28_ONE))) ? rer_pkg::Q28_ONE
                                                               : w_ssum[28:0];
    assign w_k1mag = r_k1[15] ? 16'(-r_k1) : 16'(r_k1);
    assign w_emul  = 45'(w_k1mag) * 45'(w_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= w_sin_valid[rer_pkg::SIN_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_mag <= w_emul[43:12];
            r_e_neg <= r_k1[15] ^ w_sin[rer_pkg::SIN_TERMS].tag[0];
        end
    end

    // Split the exponent into n*ln2 + f with f in [0, ln2); the quotient fits in four bits.
    logic [31:0]        w_rem;
    logic [3:0]         w_q;
    logic signed [4:0]  w_n;
    logic [27:0]        w_f;
    logic               r_d_valid;
    rer_pkg::t_ser      r_d;

    always_comb begin
        w_rem = r_e_mag;
        w_q   = 4'd0;
        for (int b = 3; b >= 0; b--) begin
            if (w_rem >= (32'(rer_pkg::Q28_LN2) << b)) begin
                w_rem  = w_rem - (32'(rer_pkg::Q28_LN2) << b);
                w_q[b] = 1'b1;
            end
        end
        if (!r_e_neg) begin
            w_n = $signed({1'b0, w_q});
            w_f = w_rem[27:0];
        end else if (w_rem != 32'd0) begin
            w_n = -$signed({1'b0, w_q}) - 5'sd1;
            w_f = rer_pkg::Q28_LN2 - w_rem[27:0];
        end else begin
            w_n = -$signed({1'b0, w_q});
            w_f = 28'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d.term <= 32'(rer_pkg::Q28_ONE);
            r_d.mult <= 32'(w_f);
            r_d.sum  <= $signed(34'(rer_pkg::Q28_ONE));
            r_d.tag  <= w_n;
        end
    end

    // Exponential series: all terms added, divisors 1..12.
    logic          w_exp_valid [0:rer_pkg::EXP_TERMS];
    rer_pkg::t_ser w_exp       [0:rer_pkg::EXP_TERMS];

    assign w_exp_valid[0] = r_d_valid;
    assign w_exp[0]       = r_d;

    for (genvar k = 1; k <= rer_pkg::EXP_TERMS; k++) begin : g_exp
        rer_series_cell #(
            .DIVISOR  (k),
            .SUBTRACT (1'b0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_exp_valid[k-1]),
            .i_data  (w_exp[k-1]),
            .o_valid (w_exp_valid[k]),
            .o_data  (w_exp[k])
        );
    end

    // Scale by k0.
    logic [61:0]       w_p;
    logic              r_p_valid;
    logic [61:0]       r_p;
    logic signed [4:0] r_p_n;

    assign w_p = 62'(r_k0) * 62'(w_exp[rer_pkg::EXP_TERMS].sum[29:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_exp_valid[rer_pkg::EXP_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p   <= w_p;
            r_p_n <= w_exp[rer_pkg::EXP_TERMS].tag;
        end
    end

    // Apply 2^n with round half up, then clamp to the Q16.16 range.
    logic signed [6:0] w_sh;
    logic [63:0]       w_rnd;
    logic [63:0]       w_res;
    logic [31:0]       w_radius;
    logic              w_sat;

    assign w_sh     = 7'sd28 - 7'(r_p_n);
    assign w_rnd    = 64'(r_p) + (64'd1 << (w_sh[5:0] - 6'd1));
    assign w_res    = w_rnd >> w_sh[5:0];
    assign w_sat    = (w_res[63:32] != 32'd0);
    assign w_radius = w_sat ? 32'hFFFF_FFFF : w_res[31:0];

    // Two-entry output queue: head drives the port, the second entry absorbs one stall.
    logic        w_push;
    logic        w_pop;
    logic [31:0] r_head_radius;
    logic        r_head_sat;
    logic [31:0] r_skid_radius;
    logic        r_skid_sat;

    assign w_push = w_en && r_p_valid;
    assign w_pop  = (r_cnt != 2'd0) && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_head_radius <= r_skid_radius;
                r_head_sat    <= r_skid_sat;
            end else if (w_push) begin
                r_head_radius <= w_radius;
                r_head_sat    <= w_sat;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_head_radius <= w_radius;
                r_head_sat    <= w_sat;
            end else begin
                r_skid_radius <= w_radius;
                r_skid_sat    <= w_sat;
            end
        end
    end

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.radius    = r_head_radius;
    assign o_out.saturated = r_head_sat;

endmodule

// File: rtl/rer_checker.sv
// Port-level checker of the exposin radius evaluator and its bind statement.
module rer_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_radius,
    input logic        i_out_saturated
);

    // A clamped result always carries the full-scale radius.
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_saturated) |-> (i_out_radius == 32'hFFFF_FFFF))
        else $error("saturated result without full-scale radius");

    // No result is offered in the first cycle after reset is released.
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !i_out_valid)
        else $error("result offered straight after reset");

    // A stalled result stays offered with the same payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_radius) && $stable(i_out_saturated)))
        else $error("stalled result changed or withdrawn");

endmodule

bind exposin_radius_evaluator_core rer_checker u_rer_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_radius    (o_out.radius),
    .i_out_saturated (o_out.saturated)
);

// File: bench/exposin_radius_evaluator_core_tb.sv
// Self-checking testbench of the exposin radius evaluator with its own fixed-point predictor.
`timescale 1ns / 1ps

module exposin_radius_evaluator_core_tb;

    // Pipeline depth of the top level, and a margin for draining.
    localparam int PIPE_DEPTH = 64;
    localparam int DRAIN_WAIT = 2 * PIPE_DEPTH + 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] radius;
        logic        saturated;
    } t_radius_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    rer_in_if  angle_ch ();
    rer_out_if radius_ch ();

    exposin_radius_evaluator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (angle_ch.sink),
        .o_out      (radius_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the coefficient registers, kept in step with every write.
    logic [31:0] k0_scale;
    logic signed [15:0] k1_range;
    logic signed [15:0] k2_winding;
    logic signed [15:0] k3_phase;

    t_radius_result pending_radii[$];
    int  mismatch_count;
    longint cycle_count;
    int  send_idle_pct;
    int  sink_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is abandoned if it goes on far longer than any correct run could.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL exposin_radius_evaluator_core");
            $finish;
        end
    end

    // |sin| of a folded angle in [0, pi/2], both in Q.28, as a truncated Taylor series.
    function automatic logic [63:0] folded_sine(input logic [63:0] m);
        logic [63:0] x2;
        logic [63:0] term;
        longint sum;
        x2 = (m * m) >> 28;
        term = m;
        sum = longint'(m);
        for (int k = 1; k <= rer_pkg::SIN_TERMS; k++) begin
            term = ((term * x2) >> 28) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(rer_pkg::Q28_ONE)) sum = longint'(rer_pkg::Q28_ONE);
        return 64'(sum);
    endfunction

    // exp(f) for f in [0, ln2), Q.28, summing one and twelve truncated terms.
    function automatic logic [63:0] reduced_exp(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'(rer_pkg::Q28_ONE);
        sum = term;
        for (int k = 1; k <= rer_pkg::EXP_TERMS; k++) begin
            term = ((term * f) >> 28) / 64'(k);
            sum += term;
        end
        return sum;
    endfunction

    // Expected radius and clamp flag for one angle under the current coefficients.
    function automatic t_radius_result predict_radius(input logic signed [31:0] theta);
        longint angle, wrapped, expo, n_oct;
        logic [63:0] m, s, mag, f, prod, rounded;
        logic sin_neg, e_neg;
        int sh;
        t_radius_result res;
        angle = longint'(k2_winding) * longint'(theta) + longint'(k3_phase) * 32768;
        wrapped = angle % longint'(rer_pkg::Q28_TWO_PI);
        if (wrapped < 0) wrapped += longint'(rer_pkg::Q28_TWO_PI);
        if (wrapped >= longint'(rer_pkg::Q28_PI)) wrapped -= longint'(rer_pkg::Q28_TWO_PI);
        sin_neg = wrapped < 0;
        m = 64'(sin_neg ? -wrapped : wrapped);
        if (m > 64'(rer_pkg::Q28_HALF_PI)) m = 64'(rer_pkg::Q28_PI) - m;
        s = folded_sine(m);
        mag = (64'(k1_range < 0 ? -longint'(k1_range) : longint'(k1_range)) * s) >> 12;
        e_neg = (k1_range < 0) != sin_neg;
        expo = e_neg ? -longint'(mag) : longint'(mag);
        // Floor division by ln2 so that the remainder is never negative.
        if (expo >= 0) n_oct = expo / longint'(rer_pkg::Q28_LN2);
        else n_oct = -((-expo + longint'(rer_pkg::Q28_LN2) - 1) / longint'(rer_pkg::Q28_LN2));
        f = 64'(expo - n_oct * longint'(rer_pkg::Q28_LN2));
        prod = 64'(k0_scale) * reduced_exp(f);
        sh = 28 - int'(n_oct);
        rounded = (prod + (64'd1 << (sh - 1))) >> sh;
        if (rounded > 64'hFFFF_FFFF) begin
            res.radius = 32'hFFFF_FFFF;
            res.saturated = 1'b1;
        end else begin
            res.radius = rounded[31:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    // Receiver: stalls at random and checks every accepted result against the oldest one due.
    always @(posedge i_clk) begin
        t_radius_result want;
        if (i_rst_n && radius_ch.valid && radius_ch.ready) begin
            if (pending_radii.size() == 0) begin
                $error("unexpected result radius=%h saturated=%b",
                    radius_ch.radius, radius_ch.saturated);
                mismatch_count++;
            end else begin
                want = pending_radii.pop_front();
                if (radius_ch.radius !== want.radius) begin
                    $error("radius: expected %h, got %h", want.radius, radius_ch.radius);
                    mismatch_count++;
                end
                if (radius_ch.saturated !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated,
                        radius_ch.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        radius_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Writes one coefficient register and mirrors it in the predictor.
    task automatic write_coeff(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            rer_pkg::CFG_SCALE_FACTOR:  k0_scale = value;
            rer_pkg::CFG_DYNAMIC_RANGE: k1_range = value[15:0];
            rer_pkg::CFG_WINDING_RATE:  k2_winding = value[15:0];
            rer_pkg::CFG_PHASE_OFFSET:  k3_phase = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one angle request, with a random idle gap before it, and queues its prediction.
    // Valid is left high after the request so that the next one can follow without a gap.
    task automatic send_angle(input logic [31:0] theta);
        while ($urandom_range(99) < send_idle_pct) begin
            angle_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        angle_ch.valid <= 1'b1;
        angle_ch.theta <= theta;
        @(posedge i_clk);
        while (!angle_ch.ready) @(posedge i_clk);
        pending_radii.push_back(predict_radius(theta));
        @(negedge i_clk);
    endtask

    // Drops valid, waits for every outstanding result, then lets the pipeline settle.
    task automatic drain_results();
        angle_ch.valid <= 1'b0;
        while (pending_radii.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        sink_stall_pct = stall_pct;
    endtask

    // Reset values with boundary angles: zero, the largest value, the sign bit alone, all ones and pi/2.
    task automatic test_reset_coefficients();
        send_angle(32'h0000_0000);
        send_angle(32'h7FFF_FFFF);
        send_angle(32'h8000_0000);
        send_angle(32'hFFFF_FFFF);
        send_angle(32'h0001_921F);
        drain_results();
    endtask

    // Largest scale and extreme gains of both signs; a radius past the output range must clamp.
    task automatic test_overflow_clamp();
        write_coeff(rer_pkg::CFG_SCALE_FACTOR, 32'hFFFF_FFFF);
        write_coeff(rer_pkg::CFG_DYNAMIC_RANGE, 32'h0000_7FFF);
        write_coeff(rer_pkg::CFG_WINDING_RATE, 32'h0000_7FFF);
        write_coeff(rer_pkg::CFG_PHASE_OFFSET, 32'h0000_7FFF);
        send_angle(32'h0001_921F);
        send_angle(32'h0000_0000);
        send_angle(32'h8000_0000);
        drain_results();
        write_coeff(rer_pkg::CFG_DYNAMIC_RANGE, 32'h0000_8000);
        write_coeff(rer_pkg::CFG_WINDING_RATE, 32'h0000_8000);
        write_coeff(rer_pkg::CFG_PHASE_OFFSET, 32'h0000_8000);
        send_angle(32'h0001_921F);
        send_angle(32'h7FFF_FFFF);
        send_angle(32'hFFFE_6DE1);
        drain_results();
    endtask

    // A zero scale gives zero whatever the exponent; an out-of-range index is ignored.
    task automatic test_zero_scale_and_bad_index();
        write_coeff(rer_pkg::CFG_SCALE_FACTOR, 32'h0000_0000);
        write_coeff(rer_pkg::CFG_DYNAMIC_RANGE, 32'h0000_7FFF);
        send_angle(32'h0001_921F);
        send_angle(32'h1234_5678);
        drain_results();
        write_coeff(3'd5, 32'hDEAD_BEEF);
        write_coeff(3'd7, 32'h0000_0001);
        send_angle(32'hFFFF_0000);
        drain_results();
    endtask

    // Random angles under a given idling pattern and a fresh random coefficient set.
    task automatic test_random_angles(input int count, input int send_pct, input int stall_pct);
        logic [31:0] theta;
        set_idling(send_pct, stall_pct);
        write_coeff(rer_pkg::CFG_SCALE_FACTOR, ($urandom_range(3) == 0) ? $urandom()
            : $urandom_range(32'h0004_0000));
        write_coeff(rer_pkg::CFG_DYNAMIC_RANGE, $urandom());
        write_coeff(rer_pkg::CFG_WINDING_RATE, $urandom());
        write_coeff(rer_pkg::CFG_PHASE_OFFSET, $urandom());
        for (int i = 0; i < count; i++) begin
            // Mostly angles within one turn either side of zero, sometimes anywhere in the range.
            if ($urandom_range(3) == 0) theta = $urandom();
            else theta = 32'($signed($urandom_range(32'h000C_0000)) - 32'sh0006_0000);
            send_angle(theta);
        end
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        angle_ch.valid = 1'b0;
        angle_ch.theta = '0;
        radius_ch.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        k0_scale = 32'd65536;
        k1_range = 16'sd0;
        k2_winding = 16'sd4096;
        k3_phase = 16'sd0;
        set_idling(0, 0);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_coefficients();
        test_overflow_clamp();
        test_zero_scale_and_bad_index();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: test_random_angles(50, 0, 0);
                1: test_random_angles(50, 78, 0);
                2: test_random_angles(50, 0, 78);
                default: test_random_angles(50, 17, 17);
            endcase
        end

        if (mismatch_count == 0) begin
            $display("PASS exposin_radius_evaluator_core");
        end else begin
            $display("FAIL exposin_radius_evaluator_core");
        end
        $finish;
    end
endmodule
